FILE: design/trpq_pkg.sv
// ----------------------------------------------------------------------------
// trpq_pkg
// Shared types and fixed constants of the timed release priority queue.
// ----------------------------------------------------------------------------
package trpq_pkg;

    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int PRIO_W      = 8;
    // most releases that one tick may produce
    localparam int MAX_RESULTS = 16;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
    // task payload bits in one slot word (order rank sits above them)
    localparam int TASK_W      = ID_W + TIME_W + PRIO_W;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_NONE_DUE = 2'd3
    } kind_t;

    // classified command passed from the front to the engine
    typedef struct packed {
        logic                is_tick;
        logic [ID_W-1:0]     task_id;
        logic [TIME_W-1:0]   time_val;   // start time on schedule, now on tick
        logic [PRIO_W-1:0]   prio;
    } cmd_t;

endpackage

FILE: design/trpq_ram.sv
// ----------------------------------------------------------------------------
// trpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module trpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/trpq_front.sv
// ----------------------------------------------------------------------------
// trpq_front
// Input side: takes stream transfers, classifies them as schedule or tick
// and buffers them in a two-entry command queue for the engine.
// ----------------------------------------------------------------------------
module trpq_front
    import trpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       in_cmd;
    logic       push, pop;

    // classify: keep the one time field the command uses
    always_comb
    begin
        in_cmd.is_tick  = s_tuser;
        in_cmd.task_id  = s_tdata[15:0];
        in_cmd.prio     = s_tdata[55:48];
        in_cmd.time_val = s_tuser ? s_tdata[87:56] : s_tdata[47:16];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: design/trpq_engine.sv
// ----------------------------------------------------------------------------
// trpq_engine
// Back end: slot store, insertion, and the release scan. Each scan pass reads
// every slot once from the slot memory, keeps the best due task (not once the
// tick's release limit is reached) and applies the rank shift left by the
// previous release. Results leave through a single output register.
// ----------------------------------------------------------------------------
module trpq_engine
    import trpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int IW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = IW + TASK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [IW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                   rd_busy_reg, rd_busy_next;
    logic                   d_valid_reg, d_valid_next;
    logic [IW-1:0]          d_idx_reg, d_idx_next;
    logic                   pend_reg, pend_next;
    logic [IW-1:0]          pend_rank_reg, pend_rank_next;
    logic                   fix_only_reg, fix_only_next;
    logic [NCNT_W-1:0]      n_reg, n_next;
    logic                   best_found_reg, best_found_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [TIME_W-1:0]      best_start_reg, best_start_next;
    logic [PRIO_W-1:0]      best_prio_reg, best_prio_next;
    logic [IW-1:0]          best_order_reg, best_order_next;
    logic                   held_valid_reg, held_valid_next;
    logic [ID_W-1:0]        held_id_reg, held_id_next;
    logic [TIME_W-1:0]      held_start_reg, held_start_next;
    logic [PRIO_W-1:0]      held_prio_reg, held_prio_next;
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [TIME_W-1:0]      out_start_reg, out_start_next;
    logic [PRIO_W-1:0]      out_prio_reg, out_prio_next;
    logic                   out_last_reg, out_last_next;

    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

    logic              out_free;
    logic [IW-1:0]     free_idx;
    logic [ID_W-1:0]   w_id;
    logic [TIME_W-1:0] w_start;
    logic [PRIO_W-1:0] w_prio;
    logic [IW-1:0]     w_order, w_order_adj;
    logic              slot_live, cand, better;

    // slot memory: {rank, priority, start, id}
    trpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .re      (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    // scan data stage: unpack, shift rank, compare against best so far
    always_comb
    begin
        w_id        = ram_rd_data[ID_W-1:0];
        w_start     = ram_rd_data[ID_W+TIME_W-1:ID_W];
        w_prio      = ram_rd_data[TASK_W-1:ID_W+TIME_W];
        w_order     = ram_rd_data[WORD_W-1:TASK_W];
        w_order_adj = (pend_reg && (w_order > pend_rank_reg)) ? w_order - 1'b1 : w_order;
        slot_live   = valid_reg[d_idx_reg];
        cand        = d_valid_reg && !fix_only_reg && slot_live && (w_start <= now_reg);
        better      = !best_found_reg
                      || (w_start < best_start_reg)
                      || ((w_start == best_start_reg)
                          && ((w_prio < best_prio_reg)
                              || ((w_prio == best_prio_reg)
                                  && (w_order_adj < best_order_reg))));
    end

    // control
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_busy_next    = rd_busy_reg;
        d_valid_next    = 1'b0;
        d_idx_next      = rd_cnt_reg;
        pend_next       = pend_reg;
        pend_rank_next  = pend_rank_reg;
        fix_only_next   = fix_only_reg;
        n_next          = n_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        best_start_next = best_start_reg;
        best_prio_next  = best_prio_reg;
        best_order_next = best_order_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        held_start_next = held_start_reg;
        held_prio_next  = held_prio_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_start_next  = out_start_reg;
        out_prio_next   = out_prio_reg;
        out_last_next   = out_last_reg;
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_wr_addr     = d_idx_reg;
        ram_wr_data     = {w_order_adj, w_prio, w_start, w_id};
        ram_re          = 1'b0;
        ram_rd_addr     = rd_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    if (cmd.is_tick)
                    begin
                        now_next        = cmd.time_val;
                        n_next          = '0;
                        pend_next       = 1'b0;
                        fix_only_next   = 1'b0;
                        best_found_next = 1'b0;
                        held_valid_next = 1'b0;
                        rd_cnt_next     = '0;
                        rd_busy_next    = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = '0;
                        out_start_next = '0;
                        out_prio_next  = '0;
                        out_last_next  = 1'b1;
                        if (count_reg == FULL_CNT)
                        begin
                            out_kind_next = KIND_REJECTED;
                        end
                        else
                        begin
                            out_kind_next        = KIND_ACCEPTED;
                            ram_we               = 1'b1;
                            ram_wr_addr          = free_idx;
                            ram_wr_data          = {IW'(count_reg), cmd.prio,
                                                    cmd.time_val, cmd.task_id};
                            valid_next[free_idx] = 1'b1;
                            count_next           = count_reg + 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // read issue
                if (rd_busy_reg)
                begin
                    ram_re       = 1'b1;
                    d_valid_next = 1'b1;
                    if (rd_cnt_reg == LAST_IDX)
                    begin
                        rd_busy_next = 1'b0;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                    end
                end
                // data stage
                if (d_valid_reg)
                begin
                    ram_we = pend_reg && slot_live;
                    if (cand && better)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = d_idx_reg;
                        best_id_next    = w_id;
                        best_start_next = w_start;
                        best_prio_next  = w_prio;
                        best_order_next = w_order_adj;
                    end
                    if (d_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (best_found_reg)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        // previous release goes out, it is not the final one
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_RELEASED;
                            out_id_next    = held_id_reg;
                            out_start_next = held_start_reg;
                            out_prio_next  = held_prio_reg;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next           = 1'b1;
                        held_id_next              = best_id_reg;
                        held_start_next           = best_start_reg;
                        held_prio_next            = best_prio_reg;
                        valid_next[best_idx_reg]  = 1'b0;
                        count_next                = count_reg - 1'b1;
                        pend_next                 = 1'b1;
                        pend_rank_next            = best_order_reg;
                        n_next                    = n_reg + 1'b1;
                        fix_only_next             = (n_reg == NCNT_W'(MAX_RESULTS - 1));
                        best_found_next           = 1'b0;
                        rd_cnt_next               = '0;
                        rd_busy_next              = 1'b1;
                        state_next                = ST_SCAN;
                    end
                end
                else if (out_free)
                begin
                    // tick done: final result
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_kind_next  = KIND_RELEASED;
                        out_id_next    = held_id_reg;
                        out_start_next = held_start_reg;
                        out_prio_next  = held_prio_reg;
                    end
                    else
                    begin
                        out_kind_next  = KIND_NONE_DUE;
                        out_id_next    = '0;
                        out_start_next = '0;
                        out_prio_next  = '0;
                    end
                    held_valid_next = 1'b0;
                    pend_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            rd_busy_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            fix_only_reg   <= 1'b0;
            n_reg          <= '0;
            best_found_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            rd_busy_reg    <= rd_busy_next;
            d_valid_reg    <= d_valid_next;
            pend_reg       <= pend_next;
            fix_only_reg   <= fix_only_next;
            n_reg          <= n_next;
            best_found_reg <= best_found_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        rd_cnt_reg     <= rd_cnt_next;
        d_idx_reg      <= d_idx_next;
        pend_rank_reg  <= pend_rank_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        best_start_reg <= best_start_next;
        best_prio_reg  <= best_prio_next;
        best_order_reg <= best_order_next;
        held_id_reg    <= held_id_next;
        held_start_reg <= held_start_next;
        held_prio_reg  <= held_prio_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_start_reg  <= out_start_next;
        out_prio_reg   <= out_prio_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_prio_reg, out_start_reg, out_id_reg};

    // occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("slot count differs from number of valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("slot count beyond queue depth");

    // a released task is always due at the tick time
    a_release_due: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_RELEASED)) |-> (out_start_reg <= now_reg))
        else $error("released task not yet due");

    // scan data only appears during a scan pass
    a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (state_reg == ST_SCAN))
        else $error("slot data returned outside a scan pass");

    // a new command is only taken when no tick is in progress
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !$past(held_valid_reg))
        else $error("command taken with a release pending");

endmodule

FILE: design/timed_release_priority_queue.sv
// A schedule result passes the front command queue and the engine output register;
// while the engine is idle and the output is ready, schedules sustain one per cycle.
// A tick runs one scan pass per released task plus a closing pass, each reading every
// slot once; the engine holds one command at a time, two more are queued in front.
// Reset clears valid bits, counters and handshakes; slot memory is not cleared.
// ----------------------------------------------------------------------------
// timed_release_priority_queue
// Store of pending tasks released by tick time, then priority, then age.
// ----------------------------------------------------------------------------
module timed_release_priority_queue
    import trpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // task_id, start, priority_req, now
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_task_id, out_start_time, out_priority
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // input classification and command queue
    trpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // slot store and release engine
    trpq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
